// ----- rtl/message_header_checksum_validator_top_defines.svh -----
// Assertion macros shared by the validator RTL.
// Each one checks on the rising edge of clk and is disabled while rst is high.
`ifndef MESSAGE_HEADER_CHECKSUM_VALIDATOR_TOP_DEFINES_SVH
`define MESSAGE_HEADER_CHECKSUM_VALIDATOR_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define MHCV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MHCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mhcv_pkg.sv -----
`timescale 1ns / 1ps

package mhcv_pkg;

  // Message format
  localparam int HEADER_BYTES = 8;
  localparam int COUNT_BITS   = 17;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Byte positions of the header fields
  localparam logic [COUNT_BITS-1:0] POS_MAGIC    = COUNT_BITS'(0);
  localparam logic [COUNT_BITS-1:0] POS_OPTION   = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] POS_LEN_HI   = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] POS_LEN_LO   = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] POS_CSUM_HI  = COUNT_BITS'(4);
  localparam logic [COUNT_BITS-1:0] POS_CSUM_LO  = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] HEADER_COUNT = COUNT_BITS'(HEADER_BYTES);

  // Checksum field stands in the sum as this word
  localparam logic [15:0] FILL_WORD = 16'hcccc;

  // Register reset values
  localparam logic [7:0] MAGIC_RESET = 8'hcc;
  localparam logic [7:0] MASK_RESET  = 8'h40;

  // Register map: index is paddr[2]
  localparam int ADDR_BITS = 3;
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_MASK  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        accept;
    logic        magic_ok;
    logic        length_ok;
    logic        checksum_checked;
    logic        checksum_ok;
    logic [15:0] computed_checksum;
  } res_word_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

// ----- rtl/message_header_checksum_validator_top.sv -----
`timescale 1ns / 1ps
// Message header validator: takes one message byte per cycle on msg while msg_stall is low
// and registers one result word per message from the byte marked last_byte. Every byte
// passes through a single adder stage (16-bit ones' complement add with end-around carry)
// between the message state registers and the result register, so bytes may arrive back
// to back at one per cycle without gaps while msg_stall is low. Results leave through an
// output register backed by a one-word skid register; msg_stall rises only while the skid
// register holds a result, i.e. when two results are waiting on a stalled res channel.
// magic_value (0x0) and sensitive_mask (0x4) are written over the APB port; the user must
// write them only while the block is idle, which the block itself does not enforce.

`include "message_header_checksum_validator_top_defines.svh"

module message_header_checksum_validator_top (
  input  logic                            clk,
  input  logic                            rst,
  // byte channel
  input  logic                            msg_valid,
  output logic                            msg_stall,
  input  mhcv_pkg::in_word_t              msg,
  // result channel
  output logic                            res_valid,
  input  logic                            res_stall,
  output mhcv_pkg::res_word_t             res,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mhcv_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // Configuration registers
  logic [7:0] magic_value;
  logic [7:0] sensitive_mask;

  // Message state
  logic [mhcv_pkg::COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [15:0] sum_acc, sum_acc_next;
  logic [7:0]  pending_high, pending_high_next;
  logic        magic_seen, magic_seen_next;
  logic [7:0]  option_byte, option_byte_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] received_sum, received_sum_next;

  // Output register and skid
  logic                res_q_valid;
  logic                skid_valid;
  mhcv_pkg::res_word_t skid;
  mhcv_pkg::res_word_t res_new;

  logic        msg_acc;
  logic        msg_end;
  logic        res_take;
  logic [mhcv_pkg::COUNT_BITS-1:0] pos;
  logic        pos_live;
  logic [15:0] upd_addend;
  logic        upd_add;
  logic [15:0] fin_addend;
  logic        fin_add;
  logic [15:0] fin_sum;
  logic [15:0] computed;
  logic        len_ok;
  logic        chk;
  logic        cok;

  assign pready    = 1'b1;
  assign msg_stall = skid_valid;
  assign msg_acc   = msg_valid && !msg_stall;
  assign msg_end   = msg_acc && msg.last_byte;
  assign res_valid = res_q_valid;
  assign res_take  = res_q_valid && !res_stall;

  // APB register write and read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value    <= mhcv_pkg::MAGIC_RESET;
      sensitive_mask <= mhcv_pkg::MASK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == mhcv_pkg::REG_MAGIC) begin
        magic_value <= pwdata[7:0];
      end else begin
        sensitive_mask <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == mhcv_pkg::REG_MASK) ? {24'b0, sensitive_mask}
                                                  : {24'b0, magic_value};

  // Header capture and running sum for the incoming byte
  always_comb begin
    pos                  = byte_count;
    pos_live             = (pos != mhcv_pkg::CNT_MAX);
    magic_seen_next      = magic_seen;
    option_byte_next     = option_byte;
    declared_length_next = declared_length;
    received_sum_next    = received_sum;
    pending_high_next    = pending_high;
    byte_count_next      = byte_count;
    upd_add              = 1'b0;
    upd_addend           = {pending_high, msg.data_byte};

    if (pos_live) begin
      if (pos == mhcv_pkg::POS_MAGIC) begin
        magic_seen_next = (msg.data_byte == magic_value);
      end else if (pos == mhcv_pkg::POS_OPTION) begin
        option_byte_next = msg.data_byte;
      end else if (pos == mhcv_pkg::POS_LEN_HI) begin
        declared_length_next[15:8] = msg.data_byte;
      end else if (pos == mhcv_pkg::POS_LEN_LO) begin
        declared_length_next[7:0] = msg.data_byte;
      end else if (pos == mhcv_pkg::POS_CSUM_HI) begin
        received_sum_next[15:8] = msg.data_byte;
      end else if (pos == mhcv_pkg::POS_CSUM_LO) begin
        received_sum_next[7:0] = msg.data_byte;
      end

      if (pos == mhcv_pkg::POS_CSUM_HI) begin
        // checksum field counts as the fill word
        upd_add    = 1'b1;
        upd_addend = mhcv_pkg::FILL_WORD;
      end else if (pos != mhcv_pkg::POS_CSUM_LO) begin
        if (!pos[0]) begin
          pending_high_next = msg.data_byte;
        end else begin
          upd_add = 1'b1;
        end
      end
      byte_count_next = pos + 1'b1;
    end

    sum_acc_next = upd_add ? mhcv_pkg::oc_add(sum_acc, upd_addend) : sum_acc;
  end

  // Result for a final byte: one adder straight from sum_acc covers the word
  // finished by this byte, the fill word, or the zero-padded odd trailing byte
  always_comb begin
    fin_add    = 1'b0;
    fin_addend = upd_addend;
    if (pos_live) begin
      if (upd_add) begin
        fin_add = 1'b1;
      end else if (pos != mhcv_pkg::POS_CSUM_LO) begin
        // even position: this byte is an odd trailing byte
        fin_add    = 1'b1;
        fin_addend = {msg.data_byte, 8'h00};
      end
    end else begin
      // saturated count is odd: pad the stored high byte
      fin_add    = 1'b1;
      fin_addend = {pending_high, 8'h00};
    end
    fin_sum  = fin_add ? mhcv_pkg::oc_add(sum_acc, fin_addend) : sum_acc;
    computed = ~fin_sum;

    len_ok = (byte_count_next != mhcv_pkg::CNT_MAX) &&
             (byte_count_next >= mhcv_pkg::HEADER_COUNT) &&
             ((byte_count_next - mhcv_pkg::HEADER_COUNT) ==
              {{(mhcv_pkg::COUNT_BITS-16){1'b0}}, declared_length_next});
    chk = |(option_byte_next & sensitive_mask);
    cok = !chk || (computed == received_sum_next);

    res_new.accept            = magic_seen_next && len_ok && cok;
    res_new.magic_ok          = magic_seen_next;
    res_new.length_ok         = len_ok;
    res_new.checksum_checked  = chk;
    res_new.checksum_ok       = cok;
    res_new.computed_checksum = computed;
  end

  // Message state registers; cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || msg_end) begin
      byte_count      <= '0;
      sum_acc         <= '0;
      pending_high    <= '0;
      magic_seen      <= 1'b0;
      option_byte     <= '0;
      declared_length <= '0;
      received_sum    <= '0;
    end else if (msg_acc) begin
      byte_count      <= byte_count_next;
      sum_acc         <= sum_acc_next;
      pending_high    <= pending_high_next;
      magic_seen      <= magic_seen_next;
      option_byte     <= option_byte_next;
      declared_length <= declared_length_next;
      received_sum    <= received_sum_next;
    end
  end

  // Output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!res_q_valid || res_take) begin
      if (skid_valid) begin
        res_q_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        res_q_valid <= msg_end;
      end
    end else if (msg_end) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_q_valid || res_take) begin
      res <= skid_valid ? skid : res_new;
    end
    if (res_q_valid && !res_take && msg_end) begin
      skid <= res_new;
    end
  end

  `MHCV_ASSERT_SAME(a_skid_behind_out, skid_valid, res_q_valid, "skid word held with empty output register")
  `MHCV_ASSERT_NEXT(a_no_phantom, msg_acc && !msg.last_byte && !res_q_valid, !res_q_valid, "result without final byte")
  `MHCV_ASSERT_NEXT(a_clear_after_end, msg_end, byte_count == '0, "message state not cleared after final byte")
  `MHCV_ASSERT_SAME(a_accept_and, res_q_valid, res.accept == (res.magic_ok && res.length_ok && res.checksum_ok), "accept disagrees with check flags")
  `MHCV_ASSERT_SAME(a_unchecked_ok, res_q_valid && !res.checksum_checked, res.checksum_ok, "checksum failed without being requested")

endmodule

// ----- bench/message_header_checksum_validator_top_tb.sv -----
`timescale 1ns / 1ps

module message_header_checksum_validator_top_tb;
  import mhcv_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [ADDR_BITS-1:0] MAGIC_ADDR = {REG_MAGIC, 2'b00};
  localparam logic [ADDR_BITS-1:0] MASK_ADDR  = {REG_MASK, 2'b00};

  typedef enum int {
    FAULT_NONE,
    FAULT_BITFLIP,
    FAULT_TRUNCATE,
    FAULT_LENGTH,
    FAULT_GARBAGE
  } frame_fault_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  in_word_t    msg = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_word_t   res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  message_header_checksum_validator_top dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared bench state
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;
  int        stuck_cycles = 0;
  int        bytes_sent = 0;
  res_word_t verdict_q[$];
  logic [7:0] frame_q[$];

  // Predictor copy of the registers and message state
  logic [7:0]            cfg_magic = MAGIC_RESET;
  logic [7:0]            cfg_mask = MASK_RESET;
  logic [COUNT_BITS-1:0] m_count = '0;
  logic [15:0]           m_sum = '0;
  logic [7:0]            m_pend = '0;
  logic                  m_magic_hit = 1'b0;
  logic [7:0]            m_option = '0;
  logic [15:0]           m_declared = '0;
  logic [15:0]           m_rx_sum = '0;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  // Advance the predictor by one accepted word; queue a verdict on the last byte
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    logic [COUNT_BITS-1:0] pos;
    logic [15:0]           sum;
    res_word_t             v;
    pos = m_count;
    if (pos != CNT_MAX) begin
      case (pos)
        POS_MAGIC:   m_magic_hit = (b == cfg_magic);
        POS_OPTION:  m_option = b;
        POS_LEN_HI:  m_declared[15:8] = b;
        POS_LEN_LO:  m_declared[7:0] = b;
        POS_CSUM_HI: begin
          m_rx_sum[15:8] = b;
          m_sum = ones_add(m_sum, FILL_WORD);
        end
        POS_CSUM_LO: m_rx_sum[7:0] = b;
        default: ;
      endcase
      if (pos != POS_CSUM_HI && pos != POS_CSUM_LO) begin
        if (!pos[0]) m_pend = b;
        else m_sum = ones_add(m_sum, {m_pend, b});
      end
      m_count = pos + 1'b1;
    end
    if (!last) return;
    // odd count pads the trailing high byte, except where it was the fill byte
    sum = m_sum;
    if (m_count[0] && m_count != POS_CSUM_HI + 1'b1) sum = ones_add(sum, {m_pend, 8'h00});
    v.computed_checksum = ~sum;
    v.magic_ok = m_magic_hit;
    v.length_ok = (m_count != CNT_MAX) && (m_count >= HEADER_COUNT) &&
                  ((m_count - HEADER_COUNT) == {{(COUNT_BITS-16){1'b0}}, m_declared});
    v.checksum_checked = |(m_option & cfg_mask);
    v.checksum_ok = !v.checksum_checked || (v.computed_checksum == m_rx_sum);
    v.accept = v.magic_ok && v.length_ok && v.checksum_ok;
    verdict_q.push_back(v);
    m_count = '0;
    m_sum = '0;
    m_pend = '0;
    m_magic_hit = 1'b0;
    m_option = '0;
    m_declared = '0;
    m_rx_sum = '0;
  endfunction

  // Result side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every accepted result word with the oldest verdict
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %h with none outstanding", res));
      end else begin
        want = verdict_q.pop_front();
        if (res.accept !== want.accept)
          report_mismatch($sformatf("accept %b, want %b", res.accept, want.accept));
        if (res.magic_ok !== want.magic_ok)
          report_mismatch($sformatf("magic_ok %b, want %b", res.magic_ok, want.magic_ok));
        if (res.length_ok !== want.length_ok)
          report_mismatch($sformatf("length_ok %b, want %b", res.length_ok, want.length_ok));
        if (res.checksum_checked !== want.checksum_checked)
          report_mismatch($sformatf("checksum_checked %b, want %b",
                                    res.checksum_checked, want.checksum_checked));
        if (res.checksum_ok !== want.checksum_ok)
          report_mismatch($sformatf("checksum_ok %b, want %b",
                                    res.checksum_ok, want.checksum_ok));
        if (res.computed_checksum !== want.computed_checksum)
          report_mismatch($sformatf("computed_checksum %h, want %h",
                                    res.computed_checksum, want.computed_checksum));
      end
    end
  end

  // Watchdog: no progress while work is outstanding
  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (res_valid && !res_stall) ||
        (!msg_valid && verdict_q.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one word, wait for it to go in, then maybe idle the sender
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_word_t w;
    w.data_byte = b;
    w.last_byte = last;
    msg_valid <= 1'b1;
    msg <= w;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    absorb_byte(b, last);
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Drop valid and let all outstanding results come out
  task automatic settle();
    msg_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phases, then psel is dropped before the next transfer
  task automatic apb_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [ADDR_BITS-1:0] addr, input logic [7:0] want);
    logic [31:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got[7:0] !== want)
      report_mismatch($sformatf("register @%0h reads %h, want %h", addr, got[7:0], want));
  endtask

  task automatic set_config(input logic [7:0] magic, input logic [7:0] mask);
    logic [31:0] unused;
    settle();
    apb_access(1'b1, MAGIC_ADDR, {24'b0, magic}, unused);
    cfg_magic = magic;
    apb_access(1'b1, MASK_ADDR, {24'b0, mask}, unused);
    cfg_mask = mask;
    check_register(MAGIC_ADDR, magic);
    check_register(MASK_ADDR, mask);
  endtask

  // Checksum over frame_q with the checksum field read as fill bytes
  function automatic logic [15:0] frame_checksum();
    logic [15:0] s;
    logic [7:0]  hi, lo;
    s = '0;
    for (int i = 0; i < frame_q.size(); i += 2) begin
      hi = (i == POS_CSUM_HI) ? FILL_WORD[15:8] : frame_q[i];
      if (i + 1 >= frame_q.size()) lo = 8'h00;
      else if (i + 1 == POS_CSUM_LO) lo = FILL_WORD[7:0];
      else lo = frame_q[i+1];
      s = ones_add(s, {hi, lo});
    end
    return ~s;
  endfunction

  task automatic seal_checksum();
    logic [15:0] c;
    c = frame_checksum();
    frame_q[POS_CSUM_HI] = c[15:8];
    frame_q[POS_CSUM_LO] = c[7:0];
  endtask

  // Well-formed frame: magic, options, true length, valid checksum, random payload
  task automatic make_frame(input logic [7:0] opt, input int plen);
    frame_q = {};
    frame_q.push_back(cfg_magic);
    frame_q.push_back(opt);
    frame_q.push_back(plen[15:8]);
    frame_q.push_back(plen[7:0]);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    for (int i = POS_CSUM_LO + 1; i < HEADER_BYTES; i++)
      frame_q.push_back(8'($urandom_range(255)));
    for (int i = 0; i < plen; i++) frame_q.push_back(8'($urandom_range(255)));
    seal_checksum();
  endtask

  task automatic send_random_frame();
    logic [7:0]   opt;
    int           plen, k, pick;
    frame_fault_e fault;
    plen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
    opt = 8'($urandom_range(255));
    if ($urandom_range(3) != 0) opt = opt | cfg_mask;
    make_frame(opt, plen);
    pick = $urandom_range(99);
    if (pick < 72) fault = FAULT_NONE;
    else if (pick < 82) fault = FAULT_BITFLIP;
    else if (pick < 90) fault = FAULT_TRUNCATE;
    else if (pick < 95) fault = FAULT_LENGTH;
    else fault = FAULT_GARBAGE;
    case (fault)
      FAULT_BITFLIP: begin
        k = $urandom_range(frame_q.size() - 1);
        frame_q[k] = frame_q[k] ^ (8'h01 << $urandom_range(7));
      end
      FAULT_TRUNCATE: begin
        k = $urandom_range(frame_q.size() - 1, 1);
        while (frame_q.size() > k) void'(frame_q.pop_back());
      end
      FAULT_LENGTH: begin
        frame_q[$urandom_range(POS_LEN_LO, POS_LEN_HI)] ^= 8'h01 << $urandom_range(7);
      end
      FAULT_GARBAGE: begin
        frame_q = {};
        k = $urandom_range(20, 1);
        for (int i = 0; i < k; i++) frame_q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    send_frame();
  endtask

  task automatic test_reset_values();
    check_register(MAGIC_ADDR, MAGIC_RESET);
    check_register(MASK_ADDR, MASK_RESET);
  endtask

  // Short frames, the fill rule, odd padding, a bad magic with no check asked
  task automatic test_directed();
    send_idle_pct = 28;
    recv_idle_pct = 65;
    settle();
    // lone magic byte: header never completes
    frame_q = {8'hcc};
    send_frame();
    // stops right after the checksum high byte, fill counted, no pad
    frame_q = {8'hcc, 8'h40, 8'h00, 8'h00, 8'hff};
    send_frame();
    // good frame with one trailing 0xff payload byte
    make_frame(8'h40, 1);
    frame_q[HEADER_BYTES] = 8'hff;
    seal_checksum();
    send_frame();
    // wrong magic, option byte clear of the mask, all-ones tail
    frame_q = {8'h00, 8'hbf, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
    send_frame();
    settle();
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle,
                                     input logic [7:0] magic, input logic [7:0] mask,
                                     input int budget);
    int start;
    set_config(magic, mask);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_frame();
    settle();
  endtask

  // Results held back for a long stretch while one-byte frames keep coming
  task automatic test_backpressure();
    set_config(8'h80, 8'h00);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)), 1'b1);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_traffic(28, 65, 8'h00, 8'hff, 630);
    test_random_traffic(65, 28, 8'hff, 8'h01, 630);
    test_random_traffic(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255, 1)), 630);
    test_backpressure();
    settle();
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
